@@ hw/rtl/mark_bitmap_engine_core_defines.svh @@
// Assertion helpers used by the checker.
`ifndef MARK_BITMAP_ENGINE_CORE_DEFINES_SVH
`define MARK_BITMAP_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/mbe_pkg.sv @@
`timescale 1ns / 1ps
package mbe_pkg;

  localparam int unsigned DEF_WORD_BITS = 64;
  localparam int unsigned DEF_NUM_WORDS = 1024;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned INDEX_W = 16;
  localparam int unsigned END_W   = 17;
  localparam int unsigned TOTAL_W = 23;

  // reciprocal divide: exact for 16-bit dividends and divisors from 5 to 256
  localparam int unsigned DIV_SHIFT = 24;
  localparam int unsigned RECIP_W   = 22;

  typedef enum logic [KIND_W-1:0] {
    KIND_TEST      = 2'd0,
    KIND_SET       = 2'd1,
    KIND_CLEAR     = 2'd2,
    KIND_CLR_RANGE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_DIV_Q,
    ST_DIV_R,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/mark_bitmap_engine_core.sv @@
`timescale 1ns / 1ps
// channel  handshake             beat fields
// -------  --------------------  ---------------------------------
// request  in_valid / in_ready   kind, bit_index, range_end
// result   out_valid / out_ready bit_was_set, bad_request
//
// Per request, a single-bit op steps through divide (quotient, remainder), read,
// write, done. A range clear divides twice, then reads and writes each word touched;
// rejected or empty requests go straight to done. out_valid rises with in_ready.
// One request at a time; the word divide unit and the single RAM port set the pace.
// Reset: all NUM_WORDS words are zero-filled before in_ready first rises.
// Result sits in an output register; the next request is taken while it waits.
module mark_bitmap_engine_core #(
  parameter int unsigned WORD_BITS = mbe_pkg::DEF_WORD_BITS,
  parameter int unsigned NUM_WORDS = mbe_pkg::DEF_NUM_WORDS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mbe_pkg::KIND_W-1:0]  kind,
  input  logic [mbe_pkg::INDEX_W-1:0] bit_index,
  input  logic [mbe_pkg::END_W-1:0]   range_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        bit_was_set,
  output logic                        bad_request
);
  import mbe_pkg::*;

  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned LW = $clog2(WORD_BITS);
  localparam int unsigned HW = $clog2(WORD_BITS + 1);
  localparam int unsigned PW = INDEX_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS);
  localparam logic [TOTAL_W-1:0] TOTAL_BITS = TOTAL_W'(NUM_WORDS * WORD_BITS);
  localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

  state_t state, state_next;

  kind_t                kind_r;
  logic [INDEX_W-1:0]   idx_r;
  logic [END_W-1:0]     end_r;
  logic                 bad_r;
  logic                 was_r;
  logic                 second;
  logic                 first_w;
  logic [INDEX_W-1:0]   dq;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        lw;
  logic [LW-1:0]        lo;
  logic [HW-1:0]        hi;
  logic [AW-1:0]        caddr;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] mem [NUM_WORDS];

  logic                 accept;
  logic                 bad_in;
  logic                 skip_in;
  logic [END_W-1:0]     end_m1;
  logic [INDEX_W-1:0]   dx;
  logic [PW-1:0]        prod;
  logic [END_W-1:0]     qw;
  logic [END_W-1:0]     dr_full;
  logic [HW-1:0]        lo_eff;
  logic [HW-1:0]        hi_eff;
  logic [WORD_BITS-1:0] range_mask;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] wdata;
  logic [AW-1:0]        mem_addr;
  logic                 mem_we;
  logic                 rd_en;
  logic                 load_out;
  logic                 walk_last;

  assign accept = in_valid && in_ready;

  always_comb begin
    if (kind_t'(kind) == KIND_CLR_RANGE) begin
      bad_in = (END_W'(bit_index) > range_end) ||
               (TOTAL_W'(range_end) > TOTAL_BITS);
    end else begin
      bad_in = TOTAL_W'(bit_index) >= TOTAL_BITS;
    end
    skip_in = bad_in ||
              ((kind_t'(kind) == KIND_CLR_RANGE) && (END_W'(bit_index) == range_end));
  end

  // shared word/offset divide unit
  assign end_m1  = end_r - END_W'(1);
  assign dx      = second ? end_m1[INDEX_W-1:0] : idx_r;
  assign prod    = PW'(dx) * PW'(RECIP);
  assign qw      = END_W'(dq) * END_W'(WORD_BITS);
  assign dr_full = END_W'(dx) - qw;

  assign walk_last = (waddr == lw);
  assign lo_eff    = first_w ? HW'(lo) : '0;
  assign hi_eff    = walk_last ? hi : HW'(WORD_BITS);
  assign bit_mask  = WORD_BITS'(1) << lo;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      range_mask[i] = (HW'(i) >= lo_eff) && (HW'(i) < hi_eff);
    end
  end

  always_comb begin
    case (kind_r)
      KIND_SET:       wdata = rdata | bit_mask;
      KIND_CLEAR:     wdata = rdata & ~bit_mask;
      KIND_CLR_RANGE: wdata = rdata & ~range_mask;
      default:        wdata = rdata;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_WIPE:  if (caddr == LAST_WORD) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = skip_in ? ST_DONE : ST_DIV_Q;
      ST_DIV_Q: state_next = ST_DIV_R;
      ST_DIV_R: begin
        if (kind_r == KIND_CLR_RANGE && !second) state_next = ST_DIV_Q;
        else state_next = ST_READ;
      end
      ST_READ:  state_next = ST_WRITE;
      ST_WRITE: begin
        if (kind_r != KIND_CLR_RANGE || walk_last) state_next = ST_DONE;
        else state_next = ST_READ;
      end
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_WIPE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    mem_we   = 1'b0;
    load_out = 1'b0;
    mem_addr = waddr;
    case (state)
      ST_WIPE: begin
        mem_we   = 1'b1;
        mem_addr = caddr;
      end
      ST_IDLE:  in_ready = 1'b1;
      ST_READ:  rd_en = 1'b1;
      ST_WRITE: mem_we = kind_r inside {KIND_SET, KIND_CLEAR, KIND_CLR_RANGE};
      ST_DONE:  load_out = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= (state == ST_WIPE) ? '0 : wdata;
    end
    if (rd_en) begin
      rdata <= mem[waddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WIPE;
      caddr     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_WIPE) caddr <= caddr + AW'(1);
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_t'(kind);
      idx_r  <= bit_index;
      end_r  <= range_end;
      bad_r  <= bad_in;
      was_r  <= 1'b0;
      second <= 1'b0;
    end
    if (state == ST_DIV_Q) begin
      dq <= INDEX_W'(prod[PW-1:DIV_SHIFT]);
    end
    if (state == ST_DIV_R) begin
      if (!second) begin
        waddr   <= dq[AW-1:0];
        lo      <= dr_full[LW-1:0];
        first_w <= 1'b1;
        second  <= 1'b1;
      end else begin
        lw <= dq[AW-1:0];
        hi <= HW'(dr_full[LW-1:0]) + HW'(1);
      end
    end
    if (state == ST_WRITE) begin
      if (kind_r != KIND_CLR_RANGE) begin
        was_r <= rdata[lo];
      end else begin
        waddr   <= waddr + AW'(1);
        first_w <= 1'b0;
      end
    end
    if (load_out) begin
      bit_was_set <= was_r;
      bad_request <= bad_r;
    end
  end

endmodule

@@ hw/rtl/mbe_checker.sv @@
`timescale 1ns / 1ps
`include "mark_bitmap_engine_core_defines.svh"
module mbe_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic bit_was_set,
  input logic bad_request
);

  `MBE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(bit_was_set) && $stable(bad_request), "result beat dropped or changed while stalled")
  `MBE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken while engine busy")
  `MBE_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(!in_ready), "result appeared without a request in flight")
  `MBE_ASSERT_NOW(a_bad_no_bit, out_valid && bad_request, !bit_was_set, "rejected request reports a set bit")

endmodule

bind mark_bitmap_engine_core mbe_checker u_mbe_checker (.*);
